### sv/assert_macros.svh
// Assertion macros used by the palette quantizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/npcq_pkg.sv
// Types and constants of the nearest palette color quantizer.
package npcq_pkg;

	localparam int ID_W   = 8;
	localparam int CH_W   = 8;
	localparam int SQ_W   = 2 * CH_W;
	localparam int DIST_W = 18;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_LEARN = 2'd2,
		OP_MAP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic            match;
		logic [SQ_W-1:0] sq_red;
		logic [SQ_W-1:0] sq_green;
		logic [SQ_W-1:0] sq_blue;
	} dist_t;

endpackage

### sv/npcq_ram.sv
// Generic single-port RAM with registered read.
module npcq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### sv/npcq_dist.sv
// Registered per-channel squared difference and equality check.
module npcq_dist (
	input  logic           clk,
	input  npcq_pkg::rgb_t pixel,
	input  npcq_pkg::rgb_t entry,
	output npcq_pkg::dist_t result_s2
);
	import npcq_pkg::*;

	logic [CH_W-1:0] d_red, d_green, d_blue;

	assign d_red   = (pixel.red   > entry.red)   ? pixel.red   - entry.red   : entry.red   - pixel.red;
	assign d_green = (pixel.green > entry.green) ? pixel.green - entry.green : entry.green - pixel.green;
	assign d_blue  = (pixel.blue  > entry.blue)  ? pixel.blue  - entry.blue  : entry.blue  - pixel.blue;

	always_ff @(posedge clk) begin
		result_s2.match    <= (pixel == entry);
		result_s2.sq_red   <= SQ_W'(d_red)   * SQ_W'(d_red);
		result_s2.sq_green <= SQ_W'(d_green) * SQ_W'(d_green);
		result_s2.sq_blue  <= SQ_W'(d_blue)  * SQ_W'(d_blue);
	end

endmodule

### sv/nearest_palette_color_quantizer_unit.sv
// Nearest palette color quantizer: palette store, learn and nearest-entry search.
// Clear and load: result registered on the cycle after the input beat.
// Learn and map: one palette entry per cycle through the RAM read port and the
// distance unit, then a drain state and a finish state before the result beat.
// One item in flight; tready returns once the result beat is taken.
// Reset clears valid marks, learned count and control; colors stay unknown.
`include "assert_macros.svh"

module nearest_palette_color_quantizer_unit #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // color_id[7:0], min_distance[25:8], zero[31:26]
	output logic [2:0]  m_tuser   // palette_empty[0], palette_full_drop[1], colour_added[2]
);
	import npcq_pkg::*;

	localparam int IW    = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	logic [PALETTE_DEPTH-1:0] valid_q;
	logic [CNT_W-1:0]         cnt_q;
	op_t                      op_q;
	rgb_t                     pix_q;
	logic [IW-1:0]            addr_q;

	logic                     any_q, found_q;
	logic [DIST_W-1:0]        best_q;
	logic [IW-1:0]            best_id_q, match_id_q;

	logic [ID_W-1:0]          color_id_q;
	logic [DIST_W-1:0]        min_dist_q;
	logic                     empty_q, drop_q, added_q;

	logic                     act_s1, v_s1, act_s2, v_s2;
	logic [IW-1:0]            idx_s1, idx_s2;
	dist_t                    dist_s2;

	logic                     ram_we;
	logic [IW-1:0]            ram_addr;
	rgb_t                     ram_wdata, ram_rdata;

	logic                     s_accept;
	op_t                      in_op;
	logic [ID_W-1:0]          in_idx;
	rgb_t                     in_rgb;
	logic                     in_range;
	logic                     full;
	logic                     learn_add;
	logic [DIST_W-1:0]        dsum;

	assign s_tready = (state_q == S_IDLE) && !m_tvalid;
	assign s_accept = s_tvalid && s_tready;
	assign in_op    = op_t'(s_tuser);
	assign in_idx   = s_tdata[7:0];
	assign in_rgb   = '{red: s_tdata[15:8], green: s_tdata[23:16], blue: s_tdata[31:24]};
	assign in_range = {1'b0, in_idx} < (ID_W + 1)'(PALETTE_DEPTH);
	assign full     = (cnt_q == CNT_W'(PALETTE_DEPTH));
	assign learn_add = (state_q == S_FINISH) && (op_q == OP_LEARN) && !found_q && !full;
	assign dsum     = DIST_W'(dist_s2.sq_red) + DIST_W'(dist_s2.sq_green)
	                + DIST_W'(dist_s2.sq_blue);

	assign m_tdata  = {6'd0, min_dist_q, color_id_q};
	assign m_tuser  = {added_q, drop_q, empty_q};

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = pix_q;
		if (s_accept && (in_op == OP_LOAD) && in_range) begin
			ram_we    = 1'b1;
			ram_addr  = IW'(in_idx);
			ram_wdata = in_rgb;
		end else if (learn_add) begin
			ram_we   = 1'b1;
			ram_addr = IW'(cnt_q);
		end
	end

	npcq_ram #(
		.WIDTH($bits(rgb_t)),
		.DEPTH(PALETTE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	npcq_dist u_dist (
		.clk      (clk),
		.pixel    (pix_q),
		.entry    (ram_rdata),
		.result_s2(dist_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= (state_q == S_SCAN);
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		v_s1   <= valid_q[addr_q];
		idx_s1 <= addr_q;
		v_s2   <= v_s1;
		idx_s2 <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			cnt_q      <= '0;
			m_tvalid   <= 1'b0;
			op_q       <= OP_CLEAR;
			pix_q      <= '0;
			addr_q     <= '0;
			any_q      <= 1'b0;
			found_q    <= 1'b0;
			best_q     <= '0;
			best_id_q  <= '0;
			match_id_q <= '0;
			color_id_q <= '0;
			min_dist_q <= '0;
			empty_q    <= 1'b0;
			drop_q     <= 1'b0;
			added_q    <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (act_s2 && v_s2) begin
				if (!any_q || (dsum < best_q)) begin
					best_q    <= dsum;
					best_id_q <= idx_s2;
				end
				any_q <= 1'b1;
				if (dist_s2.match && !found_q) begin
					found_q    <= 1'b1;
					match_id_q <= idx_s2;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						op_q       <= in_op;
						pix_q      <= in_rgb;
						addr_q     <= '0;
						any_q      <= 1'b0;
						found_q    <= 1'b0;
						color_id_q <= '0;
						min_dist_q <= '0;
						empty_q    <= 1'b0;
						drop_q     <= 1'b0;
						added_q    <= 1'b0;
						unique case (in_op)
							OP_CLEAR: begin
								valid_q  <= '0;
								cnt_q    <= '0;
								m_tvalid <= 1'b1;
							end
							OP_LOAD: begin
								color_id_q <= in_idx;
								if (in_range) begin
									valid_q[IW'(in_idx)] <= 1'b1;
								end
								m_tvalid <= 1'b1;
							end
							default: begin
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (addr_q == IW'(PALETTE_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DRAIN: begin
					if (!act_s1 && !act_s2) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (op_q == OP_LEARN) begin
						if (found_q) begin
							color_id_q <= ID_W'(match_id_q);
						end else if (!full) begin
							valid_q[IW'(cnt_q)] <= 1'b1;
							color_id_q          <= ID_W'(cnt_q);
							added_q             <= 1'b1;
							cnt_q               <= cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end else begin
						if (any_q) begin
							color_id_q <= ID_W'(best_id_q);
							min_dist_q <= best_q;
						end else begin
							empty_q <= 1'b1;
						end
					end
					m_tvalid <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_accept_while_pending, !(s_tready && m_tvalid), "input taken while result pending")
	`ASSERT_ALWAYS(a_count_bound, cnt_q <= CNT_W'(PALETTE_DEPTH), "learned count past palette depth")
	`ASSERT_IMPLIES(a_flags_exclusive, m_tvalid, $onehot0(m_tuser), "more than one result flag set")
	`ASSERT_IMPLIES(a_empty_zero, m_tvalid && empty_q, (color_id_q == '0) && (min_dist_q == '0), "empty map with nonzero result")
	`ASSERT_IMPLIES(a_add_sets_valid, learn_add, ##1 valid_q[$past(IW'(cnt_q))], "learned entry not marked valid")

endmodule

### dv/tb_nearest_palette_color_quantizer_unit.sv
// Testbench for the nearest palette color quantizer: directed table plus random stream.
module tb_nearest_palette_color_quantizer_unit;
	import npcq_pkg::*;

	localparam int DEPTH = 256;
	localparam int LIMIT = 2_000_000;
	localparam int DRAIN = DEPTH + 40;
	localparam logic [7:0] CORNERS [6] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

	typedef struct packed {
		logic [7:0]        id;
		logic [DIST_W-1:0] min_d;
		logic              empty;
		logic              drop;
		logic              added;
	} res_t;

	typedef struct {
		op_t        op;
		logic [7:0] idx;
		rgb_t       px;
		bit         typed;
		res_t       res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;

	// palette shadow
	rgb_t        pal_rgb [DEPTH];
	bit          pal_ok [DEPTH];
	int unsigned learn_slot;

	res_t        quant_pending [$];
	dir_row_t    dir_rows [$];
	int          err_count;
	int          cycles;
	bit          tx_quiet;
	bit          rx_quiet;

	nearest_palette_color_quantizer_unit #(
		.PALETTE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic res_t quantize_item(input op_t op, input logic [7:0] idx, input rgb_t px);
		res_t r;
		bit   any;
		int   best;
		int   d;
		int   dr;
		int   dg;
		int   db;
		r = '0;
		any = 1'b0;
		best = 0;
		case (op)
			OP_CLEAR: begin
				foreach (pal_ok[i]) pal_ok[i] = 1'b0;
				learn_slot = 0;
			end
			OP_LOAD: begin
				r.id = idx;
				pal_rgb[idx] = px;
				pal_ok[idx] = 1'b1;
			end
			OP_LEARN: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (pal_ok[i] && pal_rgb[i] == px) begin
						any = 1'b1;
						r.id = 8'(i);
						break;
					end
				end
				if (!any) begin
					if (learn_slot < DEPTH) begin
						pal_rgb[learn_slot] = px;
						pal_ok[learn_slot] = 1'b1;
						r.id = 8'(learn_slot);
						r.added = 1'b1;
						learn_slot++;
					end else begin
						r.drop = 1'b1;
					end
				end
			end
			default: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (pal_ok[i]) begin
						dr = int'(px.red) - int'(pal_rgb[i].red);
						dg = int'(px.green) - int'(pal_rgb[i].green);
						db = int'(px.blue) - int'(pal_rgb[i].blue);
						d = dr * dr + dg * dg + db * db;
						if (!any || d < best) begin
							best = d;
							r.id = 8'(i);
							any = 1'b1;
						end
					end
				end
				if (any) r.min_d = DIST_W'(best);
				else r.empty = 1'b1;
			end
		endcase
		return r;
	endfunction

	// random colors biased toward corners and existing entries
	function automatic rgb_t pick_color();
		rgb_t        c;
		int unsigned k;
		int unsigned start;
		int unsigned j;
		bit          hit;
		k = $urandom_range(0, 9);
		c = rgb_t'(24'($urandom));
		hit = 1'b0;
		if (k < 4) begin
			return c;
		end else if (k < 6) begin
			c.red = CORNERS[$urandom_range(0, 5)];
			c.green = CORNERS[$urandom_range(0, 5)];
			c.blue = CORNERS[$urandom_range(0, 5)];
			return c;
		end
		start = $urandom_range(0, DEPTH - 1);
		for (int i = 0; i < DEPTH && !hit; i++) begin
			j = (start + i) % DEPTH;
			if (pal_ok[j]) begin
				c = pal_rgb[j];
				hit = 1'b1;
			end
		end
		if (hit && k == 9) c.green = c.green + 8'($urandom_range(1, 3));
		return c;
	endfunction

	task automatic send_beat(input op_t op, input logic [7:0] idx, input rgb_t px,
			input bit typed, input res_t typed_res);
		int   gap;
		res_t pr;
		gap = tx_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {px.blue, px.green, px.red, idx};
		s_tuser <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pr = quantize_item(op, idx, px);
		quant_pending.insert(quant_pending.size(), typed ? typed_res : pr);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (quant_pending.size() != 0) @(posedge clk);
	endtask

	task automatic random_burst(input int count);
		int unsigned r;
		op_t         op;
		logic [7:0]  idx;
		for (int n = 0; n < count; n++) begin
			if (n % 97 == 96) hold_until_drained();
			r = $urandom_range(0, 99);
			op = (r < 2) ? OP_CLEAR : (r < 27) ? OP_LOAD : (r < 60) ? OP_LEARN : OP_MAP;
			if ($urandom_range(0, 1)) idx = 8'($urandom_range(0, 255));
			else idx = 8'(learn_slot + $urandom_range(0, 3));
			send_beat(op, idx, pick_color(), 1'b0, '0);
			if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
		end
	endtask

	// result side: random stalls, compare against oldest expectation
	initial begin
		res_t got;
		res_t want;
		int   stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 6);
			if (stall == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				@(posedge clk);
				while (!m_tvalid) @(posedge clk);
				repeat (stall - 1) @(posedge clk);
				m_tready <= 1'b1;
			end
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
			got.id = m_tdata[7:0];
			got.min_d = m_tdata[25:8];
			got.empty = m_tuser[0];
			got.drop = m_tuser[1];
			got.added = m_tuser[2];
			if (quant_pending.size() == 0) begin
				$error("result beat with no expected result: color_id %0d", got.id);
				err_count++;
			end else begin
				want = quant_pending.pop_front();
				if (got.id !== want.id) begin
					$error("color_id: expected %0d, got %0d", want.id, got.id);
					err_count++;
				end
				if (got.min_d !== want.min_d) begin
					$error("min_distance: expected %0d, got %0d", want.min_d, got.min_d);
					err_count++;
				end
				if (got.empty !== want.empty) begin
					$error("palette_empty: expected %0b, got %0b", want.empty, got.empty);
					err_count++;
				end
				if (got.drop !== want.drop) begin
					$error("palette_full_drop: expected %0b, got %0b", want.drop, got.drop);
					err_count++;
				end
				if (got.added !== want.added) begin
					$error("colour_added: expected %0b, got %0b", want.added, got.added);
					err_count++;
				end
			end
			if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
		end
	end

	initial begin
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_nearest_palette_color_quantizer_unit: errors");
		$finish;
	end

	initial begin
		rgb_t px;
		err_count = 0;
		learn_slot = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_CLEAR;
		dir_rows = '{
			'{OP_MAP,   8'h5a, 24'h000000, 1'b1, '{8'd0,   18'd0,     1'b1, 1'b0, 1'b0}},
			'{OP_LEARN, 8'h00, 24'h000000, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b1}},
			'{OP_LEARN, 8'hff, 24'hffffff, 1'b1, '{8'd1,   18'd0,     1'b0, 1'b0, 1'b1}},
			'{OP_LEARN, 8'h00, 24'h000000, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'hffffff, 1'b1, '{8'd1,   18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h0000ff, 1'b1, '{8'd0,   18'd65025, 1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h808080, 1'b0, '0},
			'{OP_CLEAR, 8'hff, 24'hffffff, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h123456, 1'b1, '{8'd0,   18'd0,     1'b1, 1'b0, 1'b0}},
			'{OP_LEARN, 8'h00, 24'hffffff, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b1}},
			'{OP_CLEAR, 8'h00, 24'h000000, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_LOAD,  8'hff, 24'hff0000, 1'b1, '{8'd255, 18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_LOAD,  8'h00, 24'h00ff00, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h000000, 1'b1, '{8'd0,   18'd65025, 1'b0, 1'b0, 1'b0}},
			'{OP_LEARN, 8'h00, 24'h010203, 1'b1, '{8'd0,   18'd0,     1'b0, 1'b0, 1'b1}},
			'{OP_MAP,   8'h00, 24'h00ff00, 1'b0, '0},
			'{OP_LEARN, 8'h00, 24'hff0000, 1'b1, '{8'd255, 18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_LOAD,  8'h80, 24'h808080, 1'b1, '{8'd128, 18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h808080, 1'b1, '{8'd128, 18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'h00, 24'h7f7f7f, 1'b0, '0},
			'{OP_LOAD,  8'h55, 24'haa55aa, 1'b1, '{8'h55,  18'd0,     1'b0, 1'b0, 1'b0}},
			'{OP_MAP,   8'haa, 24'hffffff, 1'b0, '0}
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].px, dir_rows[i].typed,
				dir_rows[i].res);
		end
		hold_until_drained();
		random_burst(500);
		// fill the palette by learning past its capacity
		send_beat(OP_CLEAR, 8'($urandom_range(0, 255)), rgb_t'(24'($urandom)), 1'b0, '0);
		for (int k = 0; k < 280; k++) begin
			px = rgb_t'(24'($urandom));
			if (k % 25 == 24) begin
				send_beat(OP_MAP, 8'($urandom_range(0, 255)), px, 1'b0, '0);
			end else begin
				px.red = 8'(k);
				send_beat(OP_LEARN, 8'($urandom_range(0, 255)), px, 1'b0, '0);
			end
		end
		random_burst(600);
		hold_until_drained();
		repeat (DRAIN) @(posedge clk);
		if (err_count == 0) begin
			$display("tb_nearest_palette_color_quantizer_unit: clean");
		end else begin
			$display("tb_nearest_palette_color_quantizer_unit: errors");
		end
		$finish;
	end

endmodule
